// ----- rtl/core/bdhr_pkg.sv -----
// Shared types and constants for the button debounce / hold-repeat core.
`timescale 1ns / 1ps
package bdhr_pkg;

	localparam int BUTTON_COUNT = 3;

	// Button roles
	localparam int BTN_MODE = 0;
	localparam int BTN_INC  = 1;
	localparam int BTN_SET  = 2;

	// Configuration register indexes
	localparam logic [1:0] CFG_DEBOUNCE_TICKS = 2'd0;
	localparam logic [1:0] CFG_HOLD_LIMIT     = 2'd1;
	localparam logic [1:0] CFG_PRESSED_LEVEL  = 2'd2;

	localparam logic [3:0] DEBOUNCE_RESET      = 4'd3;
	localparam logic [7:0] HOLD_LIMIT_RESET    = 8'd100;
	localparam logic       PRESSED_LEVEL_RESET = 1'b0;

	localparam logic [6:0] VALUE_MAX        = 7'd99;
	localparam logic [1:0] MODE_MAX         = 2'd2;
	localparam logic [1:0] MODE_LED_OFF     = 2'd1;
	localparam logic [7:0] HOLD_COUNT_MAX   = 8'd255;
	localparam logic [7:0] REPEAT_LAST      = 8'd9;

	typedef enum logic [1:0] {
		PS_RELEASED = 2'd0,
		PS_PRESSED  = 2'd1,
		PS_HOLD     = 2'd2
	} press_state_t;

	typedef struct packed {
		logic button0_level;
		logic button1_level;
		logic button2_level;
	} in_item_t;

	typedef struct packed {
		logic [6:0] count_value;
		logic       led_on;
		logic       reset_event;
		logic       set_event;
		logic [1:0] button0_state;
		logic [1:0] button1_state;
		logic [1:0] button2_state;
	} out_item_t;

	typedef struct packed {
		logic [3:0] debounce_ticks;
		logic [7:0] hold_limit;
		logic       pressed_level;
	} cfg_t;

	// What one button machine did this tick
	typedef struct packed {
		logic         fire;
		logic         led_upd;
		logic         hold_bump;
		press_state_t state;
	} btn_act_t;

	function automatic logic [6:0] bump_value(input logic [6:0] v);
		return (v >= VALUE_MAX) ? 7'd0 : v + 7'd1;
	endfunction

endpackage

// ----- rtl/core/bdhr_button.sv -----
// One button: debounce filter and released / pressed / hold-repeat machine.
`timescale 1ns / 1ps
module bdhr_button (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                level,
	input  bdhr_pkg::cfg_t      cfg,
	output bdhr_pkg::btn_act_t  act
);

	logic [3:0]             stable_cnt_q, stable_cnt_d;
	logic                   cand_q, cand_d;
	logic [7:0]             hold_cnt_q, hold_cnt_d;
	bdhr_pkg::press_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_cnt_q <= '0;
			cand_q       <= 1'b0;
			hold_cnt_q   <= '0;
			state_q      <= bdhr_pkg::PS_RELEASED;
		end else if (en) begin
			stable_cnt_q <= stable_cnt_d;
			cand_q       <= cand_d;
			hold_cnt_q   <= hold_cnt_d;
			state_q      <= state_d;
		end
	end

	always_comb begin
		logic run;
		logic pressed;
		stable_cnt_d  = stable_cnt_q;
		cand_d        = cand_q;
		hold_cnt_d    = hold_cnt_q;
		state_d       = state_q;
		act.fire      = 1'b0;
		act.led_upd   = 1'b0;
		act.hold_bump = 1'b0;
		run           = 1'b0;
		pressed       = (level == cfg.pressed_level);

		if (level != cand_q) begin
			stable_cnt_d = '0;
			cand_d       = level;
		end else if (stable_cnt_q < cfg.debounce_ticks) begin
			stable_cnt_d = stable_cnt_q + 4'd1;
		end else begin
			run = 1'b1;
		end

		if (run) begin
			unique case (state_q)
				bdhr_pkg::PS_RELEASED: begin
					if (pressed)
						state_d = bdhr_pkg::PS_PRESSED;
				end
				bdhr_pkg::PS_PRESSED: begin
					if (pressed) begin
						act.led_upd = 1'b1;
						act.fire    = (hold_cnt_q == 8'd0);
						if (hold_cnt_q <= cfg.hold_limit && hold_cnt_q != bdhr_pkg::HOLD_COUNT_MAX)
							hold_cnt_d = hold_cnt_q + 8'd1;
						else begin
							hold_cnt_d = '0;
							state_d    = bdhr_pkg::PS_HOLD;
						end
					end else begin
						hold_cnt_d = '0;
						state_d    = bdhr_pkg::PS_RELEASED;
					end
				end
				bdhr_pkg::PS_HOLD: begin
					if (pressed) begin
						act.hold_bump = (hold_cnt_q == 8'd0);
						hold_cnt_d    = (hold_cnt_q >= bdhr_pkg::REPEAT_LAST) ? 8'd0
						                : hold_cnt_q + 8'd1;
					end else begin
						hold_cnt_d = '0;
						state_d    = bdhr_pkg::PS_RELEASED;
					end
				end
				default: state_d = bdhr_pkg::PS_RELEASED;
			endcase
		end
		act.state = state_d;
	end

endmodule

// ----- rtl/core/bdhr_value.sv -----
// Shared value, mode and LED state, updated by the buttons in order 0, 1, 2.
`timescale 1ns / 1ps
module bdhr_value (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  bdhr_pkg::btn_act_t act [bdhr_pkg::BUTTON_COUNT],
	output logic [6:0]         value_nxt,
	output logic               led_nxt,
	output logic               reset_evt,
	output logic               set_evt
);

	logic [6:0] value_q;
	logic [1:0] mode_q, mode_nxt;
	logic       led_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			mode_q  <= '0;
			led_q   <= 1'b0;
		end else if (en) begin
			value_q <= value_nxt;
			mode_q  <= mode_nxt;
			led_q   <= led_nxt;
		end
	end

	always_comb begin
		logic any_led;
		value_nxt = value_q;
		mode_nxt  = mode_q;
		any_led   = 1'b0;
		for (int b = 0; b < bdhr_pkg::BUTTON_COUNT; b++) begin
			any_led = any_led | act[b].led_upd;
			if (b == bdhr_pkg::BTN_MODE && act[b].fire) begin
				value_nxt = '0;
				if (mode_nxt < bdhr_pkg::MODE_MAX)
					mode_nxt = mode_nxt + 2'd1;
			end else if ((b == bdhr_pkg::BTN_INC && act[b].fire) || act[b].hold_bump) begin
				value_nxt = bdhr_pkg::bump_value(value_nxt);
			end
		end
		// only button 0 moves the mode, so the final mode is what every LED update sees
		led_nxt   = any_led ? (mode_nxt != bdhr_pkg::MODE_LED_OFF) : led_q;
		reset_evt = act[bdhr_pkg::BTN_MODE].fire;
		set_evt   = act[bdhr_pkg::BTN_SET].fire;
	end

endmodule

// ----- rtl/core/button_debounce_hold_repeat_core.sv -----
// Top level: input register, button machines, shared value logic, result register.
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_data (three raw button levels)
//   out     | output    | out_valid/out_stall| out_data (value, LED, events, states)
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// One request per cycle while out_stall is low; an accepted request reaches out_data
// by way of the input and result registers. The per-tick work is one pass through the
// button machines between those registers, whose state feeds the next request.
// Reset puts all machines in released, value and mode at zero, registers at defaults.
// A stalled result holds; one more request is taken into the input register meanwhile.
`timescale 1ns / 1ps
module button_debounce_hold_repeat_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bdhr_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output bdhr_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data
);

	bdhr_pkg::cfg_t      cfg_q;
	logic                valid_s1, valid_s2;
	bdhr_pkg::in_item_t  data_s1;
	bdhr_pkg::out_item_t data_s2;
	logic                out_free, advance;
	logic [bdhr_pkg::BUTTON_COUNT-1:0] level;
	bdhr_pkg::btn_act_t  act [bdhr_pkg::BUTTON_COUNT];
	logic [6:0]          value_nxt;
	logic                led_nxt, reset_evt, set_evt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= bdhr_pkg::DEBOUNCE_RESET;
			cfg_q.hold_limit     <= bdhr_pkg::HOLD_LIMIT_RESET;
			cfg_q.pressed_level  <= bdhr_pkg::PRESSED_LEVEL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bdhr_pkg::CFG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= cfg_data[3:0];
				bdhr_pkg::CFG_HOLD_LIMIT:     cfg_q.hold_limit     <= cfg_data;
				bdhr_pkg::CFG_PRESSED_LEVEL:  cfg_q.pressed_level  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (out_free)
				valid_s2 <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			data_s1 <= in_data;
	end

	assign level[0] = data_s1.button0_level;
	assign level[1] = data_s1.button1_level;
	assign level[2] = data_s1.button2_level;

	for (genvar b = 0; b < bdhr_pkg::BUTTON_COUNT; b++) begin : g_btn
		bdhr_button u_btn (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (advance),
			.level  (level[b]),
			.cfg    (cfg_q),
			.act    (act[b])
		);
	end

	bdhr_value u_value (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.act       (act),
		.value_nxt (value_nxt),
		.led_nxt   (led_nxt),
		.reset_evt (reset_evt),
		.set_evt   (set_evt)
	);

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2.count_value   <= value_nxt;
			data_s2.led_on        <= led_nxt;
			data_s2.reset_event   <= reset_evt;
			data_s2.set_event     <= set_evt;
			data_s2.button0_state <= act[0].state;
			data_s2.button1_state <= act[1].state;
			data_s2.button2_state <= act[2].state;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

// ----- rtl/core/bdhr_checker.sv -----
// Port-level checks for the button debounce / hold-repeat core, bound to the top level.
`timescale 1ns / 1ps
module bdhr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input bdhr_pkg::out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.count_value <= bdhr_pkg::VALUE_MAX)
		else $error("count_value out of range");

	// button 0 fires only on its first pressed tick, then stays pressed
	a_reset_evt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.reset_event |->
			out_data.button0_state == bdhr_pkg::PS_PRESSED && out_data.count_value <= 7'd2)
		else $error("reset event with inconsistent state or value");

	a_set_evt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.set_event |-> out_data.button2_state == bdhr_pkg::PS_PRESSED)
		else $error("set event while button 2 not pressed");

endmodule

bind button_debounce_hold_repeat_core bdhr_checker u_bdhr_checker (.*);

// ----- verif/bdhr_result_checker.sv -----
// Result checker: predicts each tick of the button core and compares the results it sends.
`timescale 1ns / 1ps
module bdhr_result_checker
	import bdhr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  in_item_t   in_data,
	input  logic       out_valid,
	input  logic       out_stall,
	input  out_item_t  out_data,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output int         mismatches,
	output int         pending
);

	// register copies
	logic [3:0] deb_ticks;
	logic [7:0] hold_lim;
	logic       press_lvl;

	// per-button debounce and machine state
	logic [3:0]   stab_cnt [BUTTON_COUNT];
	logic         cand_lvl [BUTTON_COUNT];
	press_state_t btn_st   [BUTTON_COUNT];
	logic [7:0]   hold_cnt [BUTTON_COUNT];

	logic [6:0] value;
	logic [1:0] mode;
	logic       led;

	out_item_t tick_results_q[$];
	out_item_t tick_result;
	int        errors = 0;

	assign mismatches = errors;

	function automatic logic [6:0] wrap_inc(input logic [6:0] v);
		return (v < 7'd99) ? v + 7'd1 : 7'd0;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	task automatic step_buttons(input in_item_t it, output out_item_t res);
		logic [2:0] lv;
		logic       hit;
		logic       rst_ev;
		logic       set_ev;
		lv = {it.button2_level, it.button1_level, it.button0_level};
		rst_ev = 1'b0;
		set_ev = 1'b0;
		// buttons in order, so value changes stack within one tick
		for (int b = 0; b < BUTTON_COUNT; b++) begin
			if (lv[b] != cand_lvl[b]) begin
				stab_cnt[b] = 4'd0;
				cand_lvl[b] = lv[b];
			end else if (stab_cnt[b] < deb_ticks) begin
				stab_cnt[b] = stab_cnt[b] + 4'd1;
			end else begin
				hit = (lv[b] == press_lvl);
				case (btn_st[b])
					PS_RELEASED: begin
						if (hit)
							btn_st[b] = PS_PRESSED;
					end
					PS_PRESSED: begin
						if (hit) begin
							if (hold_cnt[b] == 8'd0) begin
								case (b)
									BTN_MODE: begin
										rst_ev = 1'b1;
										value = 7'd0;
										if (mode < MODE_MAX)
											mode = mode + 2'd1;
									end
									BTN_INC: value = wrap_inc(value);
									default: set_ev = 1'b1;
								endcase
							end
							led = (mode != MODE_LED_OFF);
							if (hold_cnt[b] <= hold_lim && hold_cnt[b] != HOLD_COUNT_MAX) begin
								hold_cnt[b] = hold_cnt[b] + 8'd1;
							end else begin
								hold_cnt[b] = 8'd0;
								btn_st[b] = PS_HOLD;
							end
						end else begin
							hold_cnt[b] = 8'd0;
							btn_st[b] = PS_RELEASED;
						end
					end
					PS_HOLD: begin
						if (hit) begin
							if (hold_cnt[b] == 8'd0)
								value = wrap_inc(value);
							hold_cnt[b] = (hold_cnt[b] >= REPEAT_LAST) ? 8'd0 : hold_cnt[b] + 8'd1;
						end else begin
							hold_cnt[b] = 8'd0;
							btn_st[b] = PS_RELEASED;
						end
					end
					default: btn_st[b] = PS_RELEASED;
				endcase
			end
		end
		res.count_value   = value;
		res.led_on        = led;
		res.reset_event   = rst_ev;
		res.set_event     = set_ev;
		res.button0_state = btn_st[BTN_MODE];
		res.button1_state = btn_st[BTN_INC];
		res.button2_state = btn_st[BTN_SET];
	endtask

	task automatic compare_result(input out_item_t got, input out_item_t want);
		if (got.count_value !== want.count_value)
			report_mismatch("count_value", got.count_value, want.count_value);
		if (got.led_on !== want.led_on)
			report_mismatch("led_on", got.led_on, want.led_on);
		if (got.reset_event !== want.reset_event)
			report_mismatch("reset_event", got.reset_event, want.reset_event);
		if (got.set_event !== want.set_event)
			report_mismatch("set_event", got.set_event, want.set_event);
		if (got.button0_state !== want.button0_state)
			report_mismatch("button0_state", got.button0_state, want.button0_state);
		if (got.button1_state !== want.button1_state)
			report_mismatch("button1_state", got.button1_state, want.button1_state);
		if (got.button2_state !== want.button2_state)
			report_mismatch("button2_state", got.button2_state, want.button2_state);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_ticks = DEBOUNCE_RESET;
			hold_lim  = HOLD_LIMIT_RESET;
			press_lvl = PRESSED_LEVEL_RESET;
			for (int b = 0; b < BUTTON_COUNT; b++) begin
				stab_cnt[b] = 4'd0;
				cand_lvl[b] = 1'b0;
				btn_st[b]   = PS_RELEASED;
				hold_cnt[b] = 8'd0;
			end
			value = 7'd0;
			mode  = 2'd0;
			led   = 1'b0;
			tick_results_q.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (tick_results_q.size() == 0)
					report_mismatch("result with no request outstanding", int'(out_data), 0);
				else
					compare_result(out_data, tick_results_q.pop_front());
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DEBOUNCE_TICKS: deb_ticks = cfg_data[3:0];
					CFG_HOLD_LIMIT:     hold_lim  = cfg_data;
					CFG_PRESSED_LEVEL:  press_lvl = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				step_buttons(in_data, tick_result);
				tick_results_q.push_back(tick_result);
			end
			pending <= tick_results_q.size();
		end
	end

endmodule

// ----- verif/tb_button_debounce_hold_repeat_core.sv -----
// Testbench top: drives ticks and register writes into the button core and gives the verdict.
`timescale 1ns / 1ps
module tb_button_debounce_hold_repeat_core;
	import bdhr_pkg::*;

	localparam int         WATCHDOG_LIMIT = 5000;
	localparam int         DRAIN_CYCLES   = 8;
	localparam logic [1:0] CFG_UNUSED     = 2'd3;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	in_item_t   in_data   = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_item_t  out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = CFG_DEBOUNCE_TICKS;
	logic [7:0] cfg_data  = 8'd0;

	int         mismatches;
	int         pending;
	int         quiet_cycles = 0;
	idle_mode_t idle_mode    = IDLE_NONE;

	button_debounce_hold_repeat_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bdhr_result_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	function automatic int sender_pct(input idle_mode_t m);
		case (m)
			IDLE_SENDER: return 80;
			IDLE_BOTH:   return 7;
			default:     return 0;
		endcase
	endfunction

	function automatic int receiver_pct(input idle_mode_t m);
		case (m)
			IDLE_RECEIVER: return 80;
			IDLE_BOTH:     return 7;
			default:       return 0;
		endcase
	endfunction

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < receiver_pct(idle_mode));
	end

	// ends the run when no channel moves anything for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic in_item_t levels(input logic b0, input logic b1, input logic b2);
		in_item_t it;
		it.button0_level = b0;
		it.button1_level = b1;
		it.button2_level = b2;
		return it;
	endfunction

	task automatic send_tick(input in_item_t it);
		while ($urandom_range(99) < sender_pct(idle_mode)) begin
			in_valid <= 1'b0;
			in_data  <= in_item_t'(3'($urandom_range(7)));
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// input goes quiet, then every outstanding request comes back
	task automatic settle();
		in_valid <= 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// unused bits of the debounce and pressed-level registers get random data, as does the unused index
	task automatic configure(input logic [3:0] deb, input logic [7:0] hold, input logic lvl);
		write_reg(CFG_DEBOUNCE_TICKS, {4'($urandom_range(15)), deb});
		write_reg(CFG_HOLD_LIMIT, hold);
		write_reg(CFG_PRESSED_LEVEL, {7'($urandom_range(127)), lvl});
		write_reg(CFG_UNUSED, 8'($urandom_range(255)));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input logic [3:0] deb, input logic [7:0] hold, input logic lvl,
	                         input int ticks, input int min_run, input int max_run,
	                         input int glitch_pct, input bit wrap_run, input idle_mode_t mode);
		logic       cur [BUTTON_COUNT];
		int         run_left [BUTTON_COUNT];
		logic [2:0] lv;
		settle();
		configure(deb, hold, lvl);
		idle_mode <= mode;
		for (int b = 0; b < BUTTON_COUNT; b++) begin
			cur[b] = 1'($urandom_range(1));
			run_left[b] = 0;
		end
		for (int k = 0; k < ticks; k++) begin
			if (wrap_run) begin
				// mode button idle, set button held, increment button tapped: value laps 99
				lv[BTN_MODE] = ~lvl;
				lv[BTN_INC]  = ((k / 3) % 2) ? lvl : ~lvl;
				lv[BTN_SET]  = lvl;
			end else begin
				for (int b = 0; b < BUTTON_COUNT; b++) begin
					if (run_left[b] == 0) begin
						cur[b] = ~cur[b];
						run_left[b] = ($urandom_range(99) < 25) ? $urandom_range(2, 1) :
						              $urandom_range(max_run, min_run);
					end
					run_left[b]--;
					lv[b] = cur[b] ^ ($urandom_range(99) < glitch_pct);
				end
			end
			send_tick(levels(lv[BTN_MODE], lv[BTN_INC], lv[BTN_SET]));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: all buttons through press, hold and release, then mode saturation
		configure(4'd0, 8'd1, 1'b1);
		send_tick(levels(1'b0, 1'b0, 1'b0));
		repeat (14) send_tick(levels(1'b1, 1'b1, 1'b1));
		repeat (2) send_tick(levels(1'b0, 1'b0, 1'b0));
		repeat (3) send_tick(levels(1'b1, 1'b0, 1'b0));
		repeat (2) send_tick(levels(1'b0, 1'b0, 1'b0));
		repeat (3) send_tick(levels(1'b1, 1'b0, 1'b0));

		run_phase(DEBOUNCE_RESET, HOLD_LIMIT_RESET, PRESSED_LEVEL_RESET,
		          150, 1, 30, 3, 1'b0, IDLE_NONE);
		run_phase(4'd0, 8'd0, 1'b1, 250, 1, 25, 3, 1'b0, IDLE_SENDER);
		// long holds reach the saturated hold count
		run_phase(4'd15, 8'd255, 1'b0, 400, 280, 320, 0, 1'b0, IDLE_RECEIVER);
		run_phase(4'd1, 8'd5, 1'b1, 300, 1, 40, 3, 1'b0, IDLE_BOTH);
		run_phase(4'd0, 8'd0, 1'b0, 400, 1, 1, 0, 1'b1, IDLE_NONE);
		run_phase(4'd2, 8'd12, 1'b0, 300, 1, 60, 5, 1'b0, IDLE_SENDER);

		settle();
		if (mismatches == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
